// ===== hdl/u8250_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8250_pkg
// Shared types and constants for the 8250-style UART register file.
// ----------------------------------------------------------------------------
package u8250_pkg;

	// Item opcodes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_RXBYTE = 2'd2;

	// Register offsets from the base port
	localparam logic [2:0] OFF_DATA = 3'd0;
	localparam logic [2:0] OFF_IER  = 3'd1;
	localparam logic [2:0] OFF_IIR  = 3'd2;
	localparam logic [2:0] OFF_LCR  = 3'd3;
	localparam logic [2:0] OFF_MCR  = 3'd4;
	localparam logic [2:0] OFF_LSR  = 3'd5;

	// Register bit positions
	localparam int IER_RX_EN_BIT   = 0;
	localparam int IER_THRE_EN_BIT = 1;
	localparam int LCR_DLAB_BIT    = 7;
	localparam int LSR_DR_BIT      = 0;
	localparam int LSR_THRE_BIT    = 5;

	localparam logic [7:0] LSR_THRE_TEMT = 8'h60;

	// IIR read codes
	localparam logic [7:0] IIR_NONE = 8'h01;
	localparam logic [7:0] IIR_THRE = 8'h02;
	localparam logic [7:0] IIR_RX   = 8'h04;

	localparam logic [15:0] BASE_PORT_RESET = 16'd1016;

	// Input item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] port;
		logic [7:0]  data;
	} req_t;

	// Result item
	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq_pulse;
	} rsp_t;

endpackage

// ===== hdl/uart_8250_register_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8250_register_model
// Simplified 8250 UART register file: bus writes, bus reads and received
// bytes in, one result per item out.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// req       req_valid / req_stall     req  (opcode, port, data)
// rsp       rsp_valid / rsp_stall     rsp  (read_data, tx_valid, tx_byte, irq_pulse)
// cfg       cfg_valid / cfg_ready     cfg_data (base port)
//
// One item per cycle while req_stall is low; the result is registered in the output buffer.
// State is updated at the transfer edge from combinational decode logic.
// A two-entry result buffer (register plus skid) holds results while rsp is
// stalled; req_stall rises only when both entries are full.
// Reset clears the register file; LSR comes up with THRE and TEMT set, base port at 1016.
// ----------------------------------------------------------------------------
module uart_8250_register_model
	import u8250_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic fire;
	logic full;
	rsp_t result;

	assign cfg_ready = 1'b1;
	assign req_stall = full;
	assign fire      = req_valid && !full;

	u8250_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.fire     (fire),
		.req      (req),
		.rsp      (result)
	);

	u8250_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (result),
		.full      (full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== hdl/u8250_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8250_regs
// Register file state and the per-item decode; result is formed in the same
// cycle the item is taken and handed to the output buffer.
// ----------------------------------------------------------------------------
module u8250_regs
	import u8250_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        fire,
	input  req_t        req,
	output rsp_t        rsp
);

	logic [15:0] base_port_q;
	logic [7:0]  dll_q, dlm_q, ier_q, lcr_q, mcr_q, rbr_q, lsr_q;
	logic        thre_pend_q, rx_pend_q;

	logic [7:0]  dll_n, dlm_n, ier_n, lcr_n, mcr_n, rbr_n, lsr_n;
	logic        thre_pend_n, rx_pend_n;

	logic [15:0] diff;
	logic        known;
	logic [2:0]  off;
	logic        dlab;

	// Address decode: no wrap below the base port
	always_comb begin
		diff  = req.port - base_port_q;
		known = (req.port >= base_port_q) && (diff <= 16'(OFF_LSR));
		off   = diff[2:0];
		dlab  = lcr_q[LCR_DLAB_BIT];
	end

	// Next state and result
	always_comb begin
		dll_n       = dll_q;
		dlm_n       = dlm_q;
		ier_n       = ier_q;
		lcr_n       = lcr_q;
		mcr_n       = mcr_q;
		rbr_n       = rbr_q;
		lsr_n       = lsr_q;
		thre_pend_n = thre_pend_q;
		rx_pend_n   = rx_pend_q;
		rsp         = '0;

		case (req.opcode)
			OP_WRITE: begin
				if (known) begin
					unique case (off)
						OFF_DATA: begin
							if (dlab) begin
								dll_n = req.data;
							end else begin
								rsp.tx_valid = 1'b1;
								rsp.tx_byte  = req.data;
								lsr_n        = lsr_q | LSR_THRE_TEMT;
								if (ier_q[IER_THRE_EN_BIT] && !thre_pend_q) begin
									thre_pend_n   = 1'b1;
									rsp.irq_pulse = 1'b1;
								end
							end
						end
						OFF_IER: begin
							if (dlab) begin
								dlm_n = req.data;
							end else begin
								// raise check sees the newly written enables
								ier_n = req.data;
								if (lsr_q[LSR_THRE_BIT] && req.data[IER_THRE_EN_BIT]
										&& !thre_pend_q) begin
									thre_pend_n   = 1'b1;
									rsp.irq_pulse = 1'b1;
								end
							end
						end
						OFF_LCR: lcr_n = req.data;
						OFF_MCR: mcr_n = req.data;
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (known) begin
					unique case (off)
						OFF_DATA: begin
							if (dlab) begin
								rsp.read_data = dll_q;
							end else begin
								lsr_n[LSR_DR_BIT] = 1'b0;
								rx_pend_n         = 1'b0;
								rsp.read_data     = rbr_q;
							end
						end
						OFF_IER: rsp.read_data = dlab ? dlm_q : ier_q;
						OFF_IIR: begin
							// receive first, then transmitter empty (cleared on read)
							if (rx_pend_q) begin
								rsp.read_data = IIR_RX;
							end else if (thre_pend_q) begin
								thre_pend_n   = 1'b0;
								rsp.read_data = IIR_THRE;
							end else begin
								rsp.read_data = IIR_NONE;
							end
						end
						OFF_LCR: rsp.read_data = lcr_q;
						OFF_MCR: rsp.read_data = mcr_q;
						OFF_LSR: rsp.read_data = lsr_q | LSR_THRE_TEMT;
						default: rsp.read_data = '0;
					endcase
				end
			end
			OP_RXBYTE: begin
				rbr_n             = req.data;
				lsr_n[LSR_DR_BIT] = 1'b1;
				if (ier_q[IER_RX_EN_BIT]) begin
					rx_pend_n     = 1'b1;
					rsp.irq_pulse = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Base port register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_port_q <= BASE_PORT_RESET;
		end else if (cfg_we) begin
			base_port_q <= cfg_data;
		end
	end

	// Register file state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dll_q       <= '0;
			dlm_q       <= '0;
			ier_q       <= '0;
			lcr_q       <= '0;
			mcr_q       <= '0;
			rbr_q       <= '0;
			lsr_q       <= LSR_THRE_TEMT;
			thre_pend_q <= 1'b0;
			rx_pend_q   <= 1'b0;
		end else if (fire) begin
			dll_q       <= dll_n;
			dlm_q       <= dlm_n;
			ier_q       <= ier_n;
			lcr_q       <= lcr_n;
			mcr_q       <= mcr_n;
			rbr_q       <= rbr_n;
			lsr_q       <= lsr_n;
			thre_pend_q <= thre_pend_n;
			rx_pend_q   <= rx_pend_n;
		end
	end

endmodule

// ===== hdl/u8250_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8250_obuf
// Result register with a skid entry; the upstream stall comes from a flop.
// ----------------------------------------------------------------------------
module u8250_obuf
	import u8250_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_data,
	output logic full,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	rsp_t main_q, skid_q;
	logic main_v_q, skid_v_q;
	logic pop;

	assign pop       = main_v_q && !rsp_stall;
	assign full      = skid_v_q;
	assign rsp_valid = main_v_q;
	assign rsp       = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// ===== sim/uart_8250_register_model_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8250_register_model_tb
// Self-checking bench for the 8250-style UART register file. A class models
// the register file (IER, LCR, MCR, divisor latch, RBR, LSR, pending flags)
// and predicts one response per request. Directed accesses come first. They
// are followed by random register traffic under several base-port settings,
// with random idling on both channels, a long receiver hold-off and a
// sender pause.
// ----------------------------------------------------------------------------
module uart_8250_register_model_tb;
	import u8250_pkg::*;

	// Opcode with no effect; the package names only the three real ones
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_ITEMS = 170;

	// Register file model and expected-response store
	class uart_reg_scoreboard;
		logic [15:0] base;
		logic [7:0]  dll, dlm, ier, lcr, mcr, rbr, lsr;
		logic        thre_pend, rx_pend;
		rsp_t        pending_rsp[$];
		int          errors;

		function new();
			base = BASE_PORT_RESET;
			dll = '0; dlm = '0; ier = '0; lcr = '0; mcr = '0; rbr = '0;
			lsr = LSR_THRE_TEMT;
			thre_pend = 1'b0;
			rx_pend = 1'b0;
			errors = 0;
		endfunction

		// THRE interrupt edge: only when enabled and not already pending
		function logic raise_thre();
			if (ier[IER_THRE_EN_BIT] && !thre_pend) begin
				thre_pend = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			logic        dlab;
			logic        known;
			logic [15:0] diff;
			logic [2:0]  off;
			e = '0;
			dlab = lcr[LCR_DLAB_BIT];
			known = 1'b0;
			off = '0;
			// no wrap: ports below the base are unmapped
			if (r.port >= base) begin
				diff = r.port - base;
				if (diff <= {13'd0, OFF_LSR}) begin
					known = 1'b1;
					off = diff[2:0];
				end
			end
			case (r.opcode)
				OP_WRITE: begin
					if (known) begin
						case (off)
							OFF_DATA: begin
								if (dlab) begin
									dll = r.data;
								end else begin
									e.tx_valid = 1'b1;
									e.tx_byte = r.data;
									lsr = lsr | LSR_THRE_TEMT;
									e.irq_pulse = raise_thre();
								end
							end
							OFF_IER: begin
								if (dlab) begin
									dlm = r.data;
								end else begin
									ier = r.data;
									if (lsr[LSR_THRE_BIT])
										e.irq_pulse = raise_thre();
								end
							end
							OFF_LCR: lcr = r.data;
							OFF_MCR: mcr = r.data;
							default: ;
						endcase
					end
				end
				OP_READ: begin
					if (known) begin
						case (off)
							OFF_DATA: begin
								if (dlab) begin
									e.read_data = dll;
								end else begin
									lsr[LSR_DR_BIT] = 1'b0;
									rx_pend = 1'b0;
									e.read_data = rbr;
								end
							end
							OFF_IER: e.read_data = dlab ? dlm : ier;
							OFF_IIR: begin
								// RX has priority and is not cleared by the read
								if (rx_pend) begin
									e.read_data = IIR_RX;
								end else if (thre_pend) begin
									thre_pend = 1'b0;
									e.read_data = IIR_THRE;
								end else begin
									e.read_data = IIR_NONE;
								end
							end
							OFF_LCR: e.read_data = lcr;
							OFF_MCR: e.read_data = mcr;
							OFF_LSR: e.read_data = lsr | LSR_THRE_TEMT;
							default: ;
						endcase
					end
				end
				OP_RXBYTE: begin
					rbr = r.data;
					lsr[LSR_DR_BIT] = 1'b1;
					if (ier[IER_RX_EN_BIT]) begin
						rx_pend = 1'b1;
						e.irq_pulse = 1'b1;
					end
				end
				default: ;
			endcase
			pending_rsp.push_back(e);
		endfunction

		function void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
		endfunction

		function void check_response(rsp_t act);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response with nothing expected, expected none, got 0x%0h",
					$time, act);
				return;
			end
			e = pending_rsp.pop_front();
			if (act.read_data !== e.read_data)
				report_field("read_data", e.read_data, act.read_data);
			if (act.tx_valid !== e.tx_valid)
				report_field("tx_valid", {7'd0, e.tx_valid}, {7'd0, act.tx_valid});
			if (act.tx_byte !== e.tx_byte)
				report_field("tx_byte", e.tx_byte, act.tx_byte);
			if (act.irq_pulse !== e.irq_pulse)
				report_field("irq_pulse", {7'd0, e.irq_pulse}, {7'd0, act.irq_pulse});
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	uart_reg_scoreboard sb;
	int send_idle;
	int recv_idle;
	int hold_cycles;
	int cycle_count;

	uart_8250_register_model uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("uart_8250_register_model: mismatch");
			$finish;
		end
	end

	// Response side: long hold-off when asked, else random stall
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	// Response transfer check
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	function req_t mk_req(logic [1:0] op, logic [15:0] port, logic [7:0] data);
		req_t r;
		r.opcode = op;
		r.port = port;
		r.data = data;
		return r;
	endfunction

	// Mostly mapped register traffic, some unmapped and wild ports
	function req_t random_req(logic [15:0] base);
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.opcode = OP_WRITE;
		else if (pick < 80)
			r.opcode = OP_READ;
		else if (pick < 97)
			r.opcode = OP_RXBYTE;
		else
			r.opcode = OP_NONE;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			r.port = base + 16'($urandom_range(0, 5));
		else if (pick < 90)
			r.port = base - 16'($urandom_range(1, 3));
		else if (pick < 93)
			r.port = base + 16'($urandom_range(6, 8));
		else
			r.port = 16'($urandom_range(0, 65535));
		r.data = 8'($urandom_range(0, 255));
		return r;
	endfunction

	// Offer one request; returns at the edge where it transfers
	task send_req(input req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	// Drop valid and wait for every outstanding response
	task wait_all_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Base port write, only while idle
	task write_base(input logic [15:0] value);
		wait_all_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.base = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] b;
		logic [15:0] bases[5];
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_cycles = 0;
		cycle_count = 0;
		send_idle = 38;
		recv_idle = 75;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed accesses at the reset base
		b = BASE_PORT_RESET;
		send_req(mk_req(OP_READ, b + 16'(OFF_LSR), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_IIR), 8'h00));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_IER), 8'h03));
		send_req(mk_req(OP_READ, b + 16'(OFF_IIR), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_IIR), 8'h00));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_DATA), 8'hFF));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_DATA), 8'h00));
		send_req(mk_req(OP_RXBYTE, b, 8'hA5));
		// second byte pulses again although already pending
		send_req(mk_req(OP_RXBYTE, 16'hFFFF, 8'h5A));
		send_req(mk_req(OP_READ, b + 16'(OFF_LSR), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_IIR), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_DATA), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_IIR), 8'h00));
		// divisor latch through DLAB
		send_req(mk_req(OP_WRITE, b + 16'(OFF_LCR), 8'h80));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_DATA), 8'h0C));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_IER), 8'hFF));
		send_req(mk_req(OP_READ, b + 16'(OFF_DATA), 8'h00));
		send_req(mk_req(OP_READ, b + 16'(OFF_IER), 8'h00));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_LCR), 8'h7F));
		send_req(mk_req(OP_READ, b + 16'(OFF_LCR), 8'h00));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_MCR), 8'h1F));
		send_req(mk_req(OP_READ, b + 16'(OFF_MCR), 8'h00));
		// read-only offsets ignore writes
		send_req(mk_req(OP_WRITE, b + 16'(OFF_IIR), 8'hFF));
		send_req(mk_req(OP_WRITE, b + 16'(OFF_LSR), 8'hFF));
		// unmapped: just below the base and past LSR
		send_req(mk_req(OP_READ, b - 16'd1, 8'h00));
		send_req(mk_req(OP_READ, b + 16'd6, 8'h00));
		send_req(mk_req(OP_NONE, 16'hFFFF, 8'hFF));

		// Random traffic under several base settings
		bases[0] = 16'h0000;
		bases[1] = 16'hFFFF;
		bases[2] = 16'($urandom_range(0, 65535));
		bases[3] = 16'hFFFA;
		bases[4] = BASE_PORT_RESET;
		for (int seg = 0; seg < 5; seg++) begin
			write_base(bases[seg]);
			if (seg == 2) begin
				send_idle = 75;
				recv_idle = 38;
			end else if (seg == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// receiver holds off while requests keep coming
				if (seg == 1 && i == 40)
					hold_cycles = 80;
				// sender pauses until the pipe is empty
				if (seg == 3 && i == 80)
					wait_all_results();
				send_req(random_req(sb.base));
			end
		end

		wait_all_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("uart_8250_register_model: match");
		end else begin
			$display("uart_8250_register_model: mismatch");
		end
		$finish;
	end

endmodule
